// ===== rtl/modbus_tcp_request_responder_core_macros.svh =====
// Assertion helpers for the responder core RTL.
`ifndef MODBUS_TCP_REQUEST_RESPONDER_CORE_MACROS_SVH
`define MODBUS_TCP_REQUEST_RESPONDER_CORE_MACROS_SVH

`define MTR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define MTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mtr_pkg.sv =====
`timescale 1ns / 1ps
package mtr_pkg;

  localparam int HDR_LEN       = 12;
  localparam int READ_CLIP     = 36;
  localparam int MBAP_OVERHEAD = 6;

  localparam logic [7:0] FC_READ_INPUTS  = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_WRITE_COIL   = 8'd5;

  typedef enum logic [1:0] {
    K_COIL,
    K_INPUTS,
    K_HOLDING
  } fc_kind_t;

  typedef struct packed {
    logic       reject;
    fc_kind_t   kind;
    logic [15:0] addr;
    logic [5:0]  cnt;
    logic [3:0]  hlen;
    logic [6:0]  nlast;
  } check_t;

  typedef struct packed {
    logic        wr_en;
    logic [5:0]  wr_idx;
    logic [15:0] wr_word;
    logic        rd_en;
    logic [16:0] rd_idx;
  } mem_req_t;

endpackage

// ===== rtl/mtr_store.sv =====
`timescale 1ns / 1ps
module mtr_store import mtr_pkg::*; #(
  parameter int REG_WORDS = 36
) (
  input  logic        clk,
  input  logic        rst,
  input  mem_req_t    req,
  output logic [15:0] rd_data
);

  localparam int AW = $clog2(REG_WORDS);

  logic [15:0]          mem [REG_WORDS];
  logic [REG_WORDS-1:0] vld;
  logic [8:0]           wr_ext;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  logic                 wr_ok;
  logic                 rd_in;

  assign wr_ext = 9'(req.wr_idx);
  assign waddr  = wr_ext[AW-1:0];
  assign raddr  = req.rd_idx[AW-1:0];
  assign wr_ok  = req.wr_en && (wr_ext < 9'(REG_WORDS));
  assign rd_in  = req.rd_idx < 17'(REG_WORDS);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_ok) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[waddr] <= req.wr_word;
    end
    if (req.rd_en) begin
      rd_data <= (rd_in && vld[raddr]) ? mem[raddr] : 16'd0;
    end
  end

endmodule

// ===== rtl/mtr_check.sv =====
`timescale 1ns / 1ps
module mtr_check import mtr_pkg::*; #(
  parameter int COIL_LIMIT  = 3,
  parameter int INPUT_LIMIT = 4
) (
  input  logic [HDR_LEN-1:0][7:0] hdr,
  input  logic [15:0]             total,
  output check_t                  chk
);

  logic [15:0] len_field;
  logic [15:0] cnt_raw;
  logic [5:0]  cnt_clip;
  logic        bad_frame;

  assign len_field = {hdr[4], hdr[5]};
  assign cnt_raw   = {hdr[10], hdr[11]};
  assign cnt_clip  = (cnt_raw > 16'(READ_CLIP)) ? 6'(READ_CLIP) : cnt_raw[5:0];
  assign bad_frame = (total < 16'(HDR_LEN)) || (hdr[2] != 8'd0) || (hdr[3] != 8'd0) ||
                     (len_field != total - 16'(MBAP_OVERHEAD));

  always_comb begin
    chk.addr  = {hdr[8], hdr[9]};
    chk.cnt   = '0;
    chk.kind  = K_COIL;
    chk.hlen  = 4'd12;
    chk.nlast = 7'd11;
    chk.reject = 1'b1;
    unique case (hdr[7])
      FC_WRITE_COIL: begin
        chk.reject = bad_frame || (chk.addr > 16'(COIL_LIMIT));
      end
      FC_READ_INPUTS: begin
        chk.kind   = K_INPUTS;
        chk.hlen   = 4'd10;
        chk.nlast  = 7'd9;
        chk.reject = bad_frame || ((17'(chk.addr) + 17'(cnt_raw)) > 17'(INPUT_LIMIT));
      end
      FC_READ_HOLDING: begin
        chk.kind   = K_HOLDING;
        chk.cnt    = cnt_clip;
        chk.hlen   = 4'd9;
        chk.nlast  = 7'd8 + {cnt_clip, 1'b0};
        chk.reject = bad_frame;
      end
      default: begin
        chk.reject = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/modbus_tcp_request_responder_core.sv =====
`timescale 1ns / 1ps
// Channel  Dir  tdata                                           tuser     tlast
// s_*      in   req_byte[7:0] load_index[13:8] load_word[29:14] mode      frame_last
// m_*      out  first_byte[7:0] second_byte[15:8] byte_count[17:16] rejected  last
// Frame bytes and load words are taken one per cycle while the block is idle.
// After the last frame byte the S_CHECK state checks the header, then the response is built
// byte by byte through a single byte path and a single store read port, pausing on a full output.
// Each register word is read from the store in a fetch state before its high and low bytes.
// Input is held off until the response is fully built; a stalled output stalls the build too.
// Reset is synchronous and clears the store, the header bytes and the byte count.
module modbus_tcp_request_responder_core import mtr_pkg::*; #(
  parameter int REG_WORDS   = 36,
  parameter int COIL_LIMIT  = 3,
  parameter int INPUT_LIMIT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // req_byte, load_index, load_word, zero fill
  input  logic        s_tlast,
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // first_byte, second_byte, byte_count, zero fill
  output logic        m_tlast,
  output logic        m_tuser    // rejected
);

`include "modbus_tcp_request_responder_core_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_HDR,
    S_FETCH,
    S_HI,
    S_LO
  } state_t;

  state_t                  state;
  logic [HDR_LEN-1:0][7:0] hdr;
  logic [15:0]             frame_count;
  logic [15:0]             count_inc;
  logic [15:0]             total;
  check_t                  chk_now;
  check_t                  chk;
  mem_req_t                mreq;
  logic [15:0]             rd_data;
  logic [6:0]              p;
  logic [5:0]              widx;
  logic [7:0]              held;
  logic                    have_one;
  logic                    out_valid;
  logic [7:0]              o_first;
  logic [7:0]              o_second;
  logic [1:0]              o_count;
  logic                    o_rej;
  logic                    o_last;
  logic                    in_acc;
  logic                    emit;
  logic [7:0]              ebyte;
  logic                    efinal;
  logic [7:0]              hbyte;

  assign s_tready  = (state == S_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign count_inc = (frame_count == 16'hffff) ? frame_count : frame_count + 16'd1;

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, o_count, o_second, o_first};
  assign m_tlast  = o_last;
  assign m_tuser  = o_rej;

  assign mreq.wr_en   = in_acc && s_tuser;
  assign mreq.wr_idx  = s_tdata[13:8];
  assign mreq.wr_word = s_tdata[29:14];
  assign mreq.rd_en   = (state == S_FETCH);
  assign mreq.rd_idx  = 17'(chk.addr) + 17'(widx);

  mtr_check #(
    .COIL_LIMIT  (COIL_LIMIT),
    .INPUT_LIMIT (INPUT_LIMIT)
  ) u_check (
    .hdr   (hdr),
    .total (total),
    .chk   (chk_now)
  );

  mtr_store #(
    .REG_WORDS (REG_WORDS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (mreq),
    .rd_data (rd_data)
  );

  always_comb begin
    hbyte = 8'd0;
    case (p[3:0])
      4'd0: hbyte = hdr[0];
      4'd1: hbyte = hdr[1];
      4'd4: hbyte = (chk.kind == K_COIL) ? hdr[4] : 8'd0;
      4'd5: begin
        case (chk.kind)
          K_COIL:    hbyte = hdr[5];
          K_INPUTS:  hbyte = 8'd4;
          K_HOLDING: hbyte = 8'd3 + {1'b0, chk.cnt, 1'b0};
          default:   hbyte = 8'd0;
        endcase
      end
      4'd6: hbyte = hdr[6];
      4'd7: hbyte = hdr[7];
      4'd8: begin
        case (chk.kind)
          K_COIL:    hbyte = hdr[8];
          K_INPUTS:  hbyte = 8'd1;
          K_HOLDING: hbyte = {1'b0, chk.cnt, 1'b0};
          default:   hbyte = 8'd0;
        endcase
      end
      4'd9:  hbyte = (chk.kind == K_COIL) ? hdr[9] : 8'd0;
      4'd10: hbyte = hdr[10];
      4'd11: hbyte = hdr[11];
      default: hbyte = 8'd0;
    endcase
  end

  always_comb begin
    emit   = 1'b0;
    ebyte  = 8'd0;
    efinal = 1'b0;
    unique case (state)
      S_HDR: begin
        emit   = !out_valid;
        ebyte  = hbyte;
        efinal = (p == chk.nlast);
      end
      S_HI: begin
        emit  = !out_valid;
        ebyte = rd_data[15:8];
      end
      S_LO: begin
        emit   = !out_valid;
        ebyte  = rd_data[7:0];
        efinal = (p == chk.nlast);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      hdr         <= '0;
      frame_count <= '0;
      have_one    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end

      if (emit) begin
        p <= p + 7'd1;
        if (have_one) begin
          o_first   <= held;
          o_second  <= ebyte;
          o_count   <= 2'd2;
          o_rej     <= 1'b0;
          o_last    <= efinal;
          out_valid <= 1'b1;
          have_one  <= 1'b0;
        end else if (efinal) begin
          o_first   <= ebyte;
          o_second  <= 8'd0;
          o_count   <= 2'd1;
          o_rej     <= 1'b0;
          o_last    <= 1'b1;
          out_valid <= 1'b1;
        end else begin
          held     <= ebyte;
          have_one <= 1'b1;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc && !s_tuser) begin
            if (frame_count < 16'(HDR_LEN)) begin
              hdr[frame_count[3:0]] <= s_tdata[7:0];
            end
            if (s_tlast) begin
              total       <= count_inc;
              frame_count <= '0;
              state       <= S_CHECK;
            end else begin
              frame_count <= count_inc;
            end
          end
        end
        S_CHECK: begin
          if (!out_valid) begin
            chk  <= chk_now;
            p    <= '0;
            widx <= '0;
            if (chk_now.reject) begin
              o_first   <= 8'd0;
              o_second  <= 8'd0;
              o_count   <= 2'd0;
              o_rej     <= 1'b1;
              o_last    <= 1'b1;
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end else begin
              state <= S_HDR;
            end
          end
        end
        S_HDR: begin
          if (emit) begin
            if (efinal) begin
              state <= S_IDLE;
            end else if (p == 7'(chk.hlen) - 7'd1) begin
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state <= S_HI;
        end
        S_HI: begin
          if (emit) begin
            state <= S_LO;
          end
        end
        S_LO: begin
          if (emit) begin
            widx  <= widx + 6'd1;
            state <= efinal ? S_IDLE : S_FETCH;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `MTR_ASSERT(a_idle_no_half, (state == S_IDLE) |-> !have_one, "byte left half-paired at idle")
  `MTR_ASSERT(a_reject_single, (m_tvalid && m_tuser) |-> (m_tlast && m_tdata[17:16] == 2'd0), "reject word malformed")
  `MTR_ASSERT(a_single_is_last, (m_tvalid && m_tdata[17:16] == 2'd1) |-> m_tlast, "single-byte word not last")
  `MTR_ASSERT(a_ptr_bound, (state == S_HDR || state == S_HI || state == S_LO) |-> (p <= chk.nlast), "byte pointer past response end")
  `MTR_ASSERT_NEXT(a_last_to_check, s_tvalid && s_tready && !s_tuser && s_tlast, state == S_CHECK, "frame end did not start check")

endmodule

// ===== tb/modbus_tcp_request_responder_core_test.sv =====
`timescale 1ns / 1ps
module modbus_tcp_request_responder_core_test import mtr_pkg::*;;

  localparam int REG_WORDS      = 36;
  localparam int COIL_LIMIT     = 3;
  localparam int INPUT_LIMIT    = 4;
  localparam int RANDOM_ITEMS   = 160;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [1:0] byte_count;
    logic       rejected;
    logic       last;
  } response_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // req_byte, load_index, load_word, zero fill
  logic        s_tlast;   // frame_last
  logic        s_tuser;   // mode
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // first_byte, second_byte, byte_count, zero fill
  logic        m_tlast;   // last
  logic        m_tuser;   // rejected

  logic [7:0]  hdr_shadow [HDR_LEN] = '{default: 8'h00};
  logic [15:0] frame_len = 16'd0;
  logic [15:0] store_shadow [REG_WORDS] = '{default: 16'h0000};

  response_t pending_responses[$];
  int        error_count = 0;
  int        items_sent = 0;
  int        stall_cycles = 0;
  bit        tx_idle = 1'b1;
  bit        rx_idle = 1'b1;

  modbus_tcp_request_responder_core #(
    .REG_WORDS  (REG_WORDS),
    .COIL_LIMIT (COIL_LIMIT),
    .INPUT_LIMIT(INPUT_LIMIT)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void push_response(logic [7:0] b0, logic [7:0] b1, logic [1:0] cnt,
                                        logic rej, logic lst);
    response_t r;
    r.first_byte  = b0;
    r.second_byte = b1;
    r.byte_count  = cnt;
    r.rejected    = rej;
    r.last        = lst;
    pending_responses.push_back(r);
  endfunction

  // Updates the shadow state for one accepted word and queues the responses it causes.
  function automatic void answer_request(logic mode, logic [7:0] rbyte, logic lastf,
                                         logic [5:0] idx, logic [15:0] word);
    logic [7:0]  resp [9 + 2 * READ_CLIP];
    logic [15:0] rlen;
    logic [15:0] w;
    int          total;
    int          addr;
    int          cnt;
    int          n;
    int          take;
    bit          refuse;

    if (mode) begin
      if (idx < REG_WORDS) store_shadow[idx] = word;
      return;
    end
    if (frame_len < HDR_LEN) hdr_shadow[frame_len] = rbyte;
    if (frame_len != 16'hffff) frame_len = frame_len + 16'd1;
    if (!lastf) return;
    total = frame_len;
    frame_len = 16'd0;

    refuse = (total < HDR_LEN) || (hdr_shadow[2] != 8'h00) || (hdr_shadow[3] != 8'h00) ||
             (int'({hdr_shadow[4], hdr_shadow[5]}) != total - MBAP_OVERHEAD);
    addr = {hdr_shadow[8], hdr_shadow[9]};
    cnt  = {hdr_shadow[10], hdr_shadow[11]};
    n = 0;
    resp[0] = hdr_shadow[0];
    resp[1] = hdr_shadow[1];
    resp[2] = 8'h00;
    resp[3] = 8'h00;
    resp[6] = hdr_shadow[6];
    if (!refuse) begin
      case (hdr_shadow[7])
        FC_WRITE_COIL: begin
          if (addr > COIL_LIMIT) begin
            refuse = 1'b1;
          end else begin
            for (int i = 4; i < HDR_LEN; i++) resp[i] = hdr_shadow[i];
            n = 12;
          end
        end
        FC_READ_INPUTS: begin
          if (addr + cnt > INPUT_LIMIT) begin
            refuse = 1'b1;
          end else begin
            resp[4] = 8'h00;
            resp[5] = 8'h04;
            resp[7] = FC_READ_INPUTS;
            resp[8] = 8'h01;
            resp[9] = 8'h00;
            n = 10;
          end
        end
        FC_READ_HOLDING: begin
          if (cnt > READ_CLIP) cnt = READ_CLIP;
          rlen = 16'(3 + 2 * cnt);
          resp[4] = rlen[15:8];
          resp[5] = rlen[7:0];
          resp[7] = FC_READ_HOLDING;
          resp[8] = 8'(2 * cnt);
          for (int i = 0; i < cnt; i++) begin
            w = (addr + i < REG_WORDS) ? store_shadow[addr + i] : 16'h0000;
            resp[9 + 2 * i]  = w[15:8];
            resp[10 + 2 * i] = w[7:0];
          end
          n = 9 + 2 * cnt;
        end
        default: refuse = 1'b1;
      endcase
    end

    if (refuse) begin
      push_response(8'h00, 8'h00, 2'd0, 1'b1, 1'b1);
      return;
    end
    for (int p = 0; p < n; p += take) begin
      take = (n - p >= 2) ? 2 : 1;
      push_response(resp[p], (take == 2) ? resp[p + 1] : 8'h00, 2'(take), 1'b0,
                    (p + take >= n));
    end
  endfunction

  task automatic send_word(logic mode, logic [7:0] rbyte, logic lastf, logic [5:0] idx,
                           logic [15:0] word);
    int gap;
    gap = tx_idle ? $urandom_range(15, 0) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tlast  <= lastf;
    s_tdata  <= {2'b00, word, idx, rbyte};
    do @(posedge clk); while (!s_tready);
    answer_request(mode, rbyte, lastf, idx, word);
    if (!(mode && idx >= REG_WORDS)) items_sent++;
  endtask

  task automatic send_load(logic [5:0] idx, logic [15:0] word);
    send_word(1'b1, 8'($urandom), 1'($urandom), idx, word);
  endtask

  task automatic send_frame(byte_q_t f);
    foreach (f[i])
      send_word(1'b0, f[i], (i == f.size() - 1), 6'($urandom), 16'($urandom));
  endtask

  function automatic byte_q_t build_frame(logic [15:0] proto, logic [15:0] len_field,
                                          logic [7:0] fc, logic [15:0] addr,
                                          logic [15:0] cnt, int extra);
    byte_q_t     f;
    logic [15:0] tid;
    logic [7:0]  unit;
    tid  = 16'($urandom);
    unit = 8'($urandom);
    f = '{tid[15:8], tid[7:0], proto[15:8], proto[7:0], len_field[15:8], len_field[7:0],
          unit, fc, addr[15:8], addr[7:0], cnt[15:8], cnt[7:0]};
    repeat (extra) f.push_back(8'($urandom));
    return f;
  endfunction

  task automatic send_request(logic [7:0] fc, logic [15:0] addr, logic [15:0] cnt,
                              int extra);
    send_frame(build_frame(16'h0000, 16'(MBAP_OVERHEAD + extra), fc, addr, cnt, extra));
  endtask

  task automatic test_loads();
    send_load(6'd0, 16'hffff);
    send_load(6'd35, 16'h8001);
    send_load(6'd1, 16'h1234);
    send_load(6'd34, 16'h00ff);
    // Indexes past the store must leave it untouched.
    send_load(6'd36, 16'hdead);
    send_load(6'd63, 16'hbeef);
  endtask

  task automatic test_supported_requests();
    send_request(FC_WRITE_COIL, 16'(COIL_LIMIT), 16'hff00, 0);
    send_request(FC_WRITE_COIL, 16'(COIL_LIMIT + 1), 16'h0000, 0);
    send_request(FC_READ_INPUTS, 16'd0, 16'(INPUT_LIMIT), 0);
    send_request(FC_READ_INPUTS, 16'd1, 16'(INPUT_LIMIT), 0);
    send_request(FC_READ_INPUTS, 16'(INPUT_LIMIT), 16'd0, 0);
    send_request(FC_READ_HOLDING, 16'd0, 16'(READ_CLIP), 0);
    send_request(FC_READ_HOLDING, 16'd34, 16'd100, 0);
    send_request(FC_READ_HOLDING, 16'hffff, 16'hffff, 0);
    send_request(FC_READ_HOLDING, 16'd5, 16'd0, 0);
    send_request(FC_READ_HOLDING, 16'd35, 16'd1, 2);
  endtask

  task automatic test_refused_requests();
    byte_q_t f;
    send_request(8'h00, 16'd0, 16'd1, 0);
    send_request(8'hff, 16'd0, 16'd1, 0);
    send_frame(build_frame(16'h0100, 16'(MBAP_OVERHEAD), FC_READ_HOLDING, 16'd0, 16'd1, 0));
    send_frame(build_frame(16'h0001, 16'(MBAP_OVERHEAD), FC_READ_HOLDING, 16'd0, 16'd1, 0));
    send_frame(build_frame(16'h0000, 16'(MBAP_OVERHEAD + 1), FC_WRITE_COIL, 16'd0, 16'd0, 0));
    f = build_frame(16'h0000, 16'(MBAP_OVERHEAD), FC_WRITE_COIL, 16'd0, 16'd0, 0);
    void'(f.pop_back());
    send_frame(f);
    send_frame('{8'h5a});
  endtask

  task automatic send_broken_request();
    byte_q_t     f;
    logic [15:0] len_field;
    logic [7:0]  fc;
    int          extra;
    extra = $urandom_range(3, 0);
    case ($urandom_range(3, 0))
      0: f = build_frame(16'($urandom_range(65535, 1)), 16'(MBAP_OVERHEAD + extra),
                         FC_READ_HOLDING, 16'd0, 16'd2, extra);
      1: begin
        len_field = 16'($urandom);
        if (len_field == MBAP_OVERHEAD + extra) len_field[0] = ~len_field[0];
        f = build_frame(16'h0000, len_field, FC_READ_INPUTS, 16'd0, 16'd1, extra);
      end
      2: begin
        f = build_frame(16'h0000, 16'(MBAP_OVERHEAD), FC_WRITE_COIL, 16'd0, 16'd0, 0);
        extra = $urandom_range(HDR_LEN - 1, 1);
        while (f.size() > extra) void'(f.pop_back());
      end
      default: begin
        do fc = 8'($urandom);
        while (fc == FC_READ_INPUTS || fc == FC_READ_HOLDING || fc == FC_WRITE_COIL);
        f = build_frame(16'h0000, 16'(MBAP_OVERHEAD + extra), fc, 16'd0, 16'd1, extra);
      end
    endcase
    send_frame(f);
  endtask

  task automatic send_random_request();
    logic [15:0] addr;
    logic [15:0] cnt;
    int          extra;
    extra = ($urandom_range(3, 0) == 0) ? $urandom_range(4, 1) : 0;
    case ($urandom_range(2, 0))
      0: send_request(FC_WRITE_COIL, 16'($urandom_range(COIL_LIMIT + 2, 0)),
                      16'($urandom), extra);
      1: send_request(FC_READ_INPUTS, 16'($urandom_range(INPUT_LIMIT + 1, 0)),
                      16'($urandom_range(INPUT_LIMIT + 1, 0)), extra);
      default: begin
        addr = ($urandom_range(7, 0) == 0) ? 16'($urandom) : 16'($urandom_range(40, 0));
        cnt  = ($urandom_range(7, 0) == 0) ? 16'($urandom) : 16'($urandom_range(12, 0));
        send_request(FC_READ_HOLDING, addr, cnt, extra);
      end
    endcase
  endtask

  task automatic test_random_traffic();
    byte_q_t f;
    int      base;
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      tx_idle = ($urandom_range(3, 0) != 0);
      rx_idle = ($urandom_range(3, 0) != 0);
      case ($urandom_range(9, 0)) inside
        [0:1]: begin
          repeat ($urandom_range(3, 1)) begin
            if ($urandom_range(7, 0) == 0) send_load(6'($urandom_range(63, REG_WORDS)),
                                                     16'($urandom));
            else send_load(6'($urandom_range(REG_WORDS - 1, 0)), 16'($urandom));
          end
        end
        8: send_broken_request();
        9: begin
          f = {};
          repeat ($urandom_range(16, 1)) f.push_back(8'($urandom));
          send_frame(f);
        end
        default: send_random_request();
      endcase
    end
  endtask

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, got_v);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    response_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_responses.size() == 0) begin
        $error("response word with no response expected: tdata %0h", m_tdata);
        error_count++;
      end else begin
        exp_r = pending_responses.pop_front();
        check_field("first_byte", exp_r.first_byte, m_tdata[7:0]);
        check_field("second_byte", exp_r.second_byte, m_tdata[15:8]);
        check_field("byte_count", 8'(exp_r.byte_count), 8'(m_tdata[17:16]));
        check_field("rejected", 8'(exp_r.rejected), 8'(m_tuser));
        check_field("last", 8'(exp_r.last), 8'(m_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("modbus_tcp_request_responder_core_test: done, errors");
      $finish;
    end
  end

  initial begin
    int gap;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = rx_idle ? $urandom_range(15, 0) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= 32'd0;
    s_tlast  <= 1'b0;
    s_tuser  <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_loads();
    test_supported_requests();
    test_refused_requests();
    test_random_traffic();

    s_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("modbus_tcp_request_responder_core_test: done, clean");
    end else begin
      $display("modbus_tcp_request_responder_core_test: done, errors");
    end
    $finish;
  end

endmodule
